[src/itp_pkg.sv]
// ----------------------------------------------------------------------------
// itp_pkg
// Types and constants shared by the infix to prefix converter.
// ----------------------------------------------------------------------------
`default_nettype none
package itp_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       is_last;
    } itp_in_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic [1:0] status;
        logic       end_of_run;
    } itp_out_t;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_UNBALANCED = 2'd1;
    localparam logic [1:0] ST_TOO_LONG   = 2'd2;

    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_LBRC  = 8'h7B;
    localparam logic [7:0] CH_RBRC  = 8'h7D;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_CARET = 8'h5E;

    typedef enum logic [3:0] {
        S_LOAD,
        S_CHK_RD,
        S_CHK,
        S_CNV_RD,
        S_CNV,
        S_POP_RD,
        S_POP,
        S_FLUSH_RD,
        S_FLUSH,
        S_EMIT_RD,
        S_EMIT,
        S_RESULT
    } itp_state_t;

    function automatic logic is_operand(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic [1:0] prec_of(input logic [7:0] c);
        if (c == CH_PLUS || c == CH_MINUS) return 2'd1;
        if (c == CH_STAR || c == CH_SLASH) return 2'd2;
        if (c == CH_CARET) return 2'd3;
        return 2'd0;
    endfunction

endpackage
`default_nettype wire

[src/infix_to_prefix_converter_unit.sv]
// Operation: load beats, then a bracket check pass and a conversion pass with
// stack pops (one stack access per step), then the result beats.
// Throughput: one expression at a time; s_ready is high only while loading.
// Reset: aresetn synchronous active low clears counts, flags and the sequencer;
// buffer and stack contents are not cleared.
// ----------------------------------------------------------------------------
// infix_to_prefix_converter_unit
// Buffers an infix expression, checks bracket nesting, converts to prefix.
// ----------------------------------------------------------------------------
`default_nettype none
module infix_to_prefix_converter_unit #(
    parameter int MAX_LEN = 64
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              s_valid,
    output logic             s_ready,
    input  itp_pkg::itp_in_t s_data,
    output logic             m_valid,
    input  wire              m_ready,
    output itp_pkg::itp_out_t m_data
);
    import itp_pkg::*;

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam logic [CW-1:0] MAXC = CW'(MAX_LEN);

    logic [7:0] in_mem  [MAX_LEN];
    logic [7:0] stk_mem [MAX_LEN];
    logic [7:0] out_mem [MAX_LEN];

    itp_state_t state_reg, state_next;
    logic [CW-1:0] in_cnt_reg, in_cnt_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] sp_reg, sp_next;
    logic [CW-1:0] oc_reg, oc_next;
    logic          tl_reg, tl_next;
    logic [7:0]    cur_reg, cur_next;
    logic [7:0]    in_rd, stk_rd, out_rd;
    itp_out_t      res_reg, res_next;
    logic          mv_reg, mv_next;

    // push / output-write requests
    logic          push_en, emit_en;
    logic [7:0]    push_val, emit_val;
    logic [AW-1:0] in_ra, stk_ra, out_ra;

    logic [7:0] cur_sw;
    logic       stk_empty;
    logic [7:0] want;

    assign stk_empty = (sp_reg == '0);
    assign cur_sw = (in_rd == CH_LPAR) ? CH_RPAR : (in_rd == CH_RPAR) ? CH_LPAR : in_rd;
    assign want = (in_rd == CH_RPAR) ? CH_LPAR : (in_rd == CH_RBRC) ? CH_LBRC : CH_LBRK;

    // read addresses, chosen combinationally and registered in memory
    always_comb begin
        in_ra  = idx_next[AW-1:0];
        stk_ra = (sp_next == '0) ? '0 : AW'(sp_next - 1'b1);
        out_ra = (oc_next == '0) ? '0 : AW'(oc_next - 1'b1);
    end

    // memories
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready && in_cnt_reg < MAXC) begin
            in_mem[in_cnt_reg[AW-1:0]] <= s_data.char_code;
        end
        if (push_en) begin
            stk_mem[sp_reg[AW-1:0]] <= push_val;
        end
        if (emit_en) begin
            out_mem[oc_reg[AW-1:0]] <= emit_val;
        end
        in_rd  <= in_mem[in_ra];
        stk_rd <= (push_en && sp_next != '0 && AW'(sp_next - 1'b1) == sp_reg[AW-1:0])
                  ? push_val : stk_mem[stk_ra];
        out_rd <= out_mem[out_ra];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD: begin
                if (s_valid && s_ready && s_data.is_last) begin
                    if (tl_reg || in_cnt_reg >= MAXC) state_next = S_RESULT;
                    else state_next = S_CHK_RD;
                end
            end
            S_CHK_RD: state_next = S_CHK;
            S_CHK: begin
                if ((in_rd == CH_RPAR || in_rd == CH_RBRC || in_rd == CH_RBRK) &&
                    (stk_empty || stk_rd != want)) state_next = S_RESULT;
                else if (idx_reg + 1'b1 >= in_cnt_reg) begin
                    if (sp_next == '0) state_next = S_CNV_RD;
                    else state_next = S_RESULT;
                end else state_next = S_CHK_RD;
            end
            S_CNV_RD: state_next = S_CNV;
            S_CNV: begin
                if (is_operand(cur_sw) || cur_sw == CH_LPAR) begin
                    state_next = (idx_reg == '0) ? S_FLUSH_RD : S_CNV_RD;
                end else state_next = S_POP_RD;
            end
            S_POP_RD: state_next = S_POP;
            S_POP: begin
                if (cur_reg == CH_RPAR) begin
                    if (!stk_empty && stk_rd != CH_LPAR) state_next = S_POP_RD;
                    else state_next = (idx_reg == '0) ? S_FLUSH_RD : S_CNV_RD;
                end else begin
                    if (!stk_empty && prec_of(stk_rd) > prec_of(cur_reg))
                        state_next = S_POP_RD;
                    else state_next = (idx_reg == '0) ? S_FLUSH_RD : S_CNV_RD;
                end
            end
            S_FLUSH_RD: state_next = S_FLUSH;
            S_FLUSH: begin
                if (!stk_empty) state_next = S_FLUSH_RD;
                else if (oc_reg == '0) state_next = S_RESULT;
                else state_next = S_EMIT_RD;
            end
            S_EMIT_RD: state_next = S_EMIT;
            S_EMIT: state_next = (m_valid && m_ready && res_reg.end_of_run) ? S_LOAD
                                 : (m_valid && m_ready) ? S_EMIT_RD : S_EMIT;
            S_RESULT: state_next = (m_valid && m_ready) ? S_LOAD : S_RESULT;
            default: state_next = S_LOAD;
        endcase
    end

    // datapath and outputs
    always_comb begin
        in_cnt_next = in_cnt_reg;
        idx_next    = idx_reg;
        sp_next     = sp_reg;
        oc_next     = oc_reg;
        tl_next     = tl_reg;
        cur_next    = cur_reg;
        res_next    = res_reg;
        mv_next     = mv_reg;
        push_en     = 1'b0;
        push_val    = cur_sw;
        emit_en     = 1'b0;
        emit_val    = stk_rd;
        s_ready     = (state_reg == S_LOAD);
        unique case (state_reg)
            S_LOAD: begin
                if (s_valid) begin
                    if (in_cnt_reg < MAXC) in_cnt_next = in_cnt_reg + 1'b1;
                    else tl_next = 1'b1;
                    if (s_data.is_last) begin
                        idx_next = '0;
                        sp_next  = '0;
                        oc_next  = '0;
                        if (tl_reg || in_cnt_reg >= MAXC) begin
                            res_next = '{8'd0, 1'b0, ST_TOO_LONG, 1'b1};
                            mv_next  = 1'b1;
                        end
                    end
                end
            end
            S_CHK_RD: ;
            S_CHK: begin
                if (in_rd == CH_LPAR || in_rd == CH_LBRC || in_rd == CH_LBRK) begin
                    push_en  = 1'b1;
                    push_val = in_rd;
                    sp_next  = sp_reg + 1'b1;
                end else if (in_rd == CH_RPAR || in_rd == CH_RBRC || in_rd == CH_RBRK) begin
                    if (!stk_empty && stk_rd == want) sp_next = sp_reg - 1'b1;
                end
                if ((in_rd == CH_RPAR || in_rd == CH_RBRC || in_rd == CH_RBRK) &&
                    (stk_empty || stk_rd != want)) begin
                    res_next = '{8'd0, 1'b0, ST_UNBALANCED, 1'b1};
                    mv_next  = 1'b1;
                end else if (idx_reg + 1'b1 >= in_cnt_reg) begin
                    if (sp_next == '0) begin
                        idx_next = in_cnt_reg - 1'b1;
                    end else begin
                        res_next = '{8'd0, 1'b0, ST_UNBALANCED, 1'b1};
                        mv_next  = 1'b1;
                    end
                end else idx_next = idx_reg + 1'b1;
            end
            S_CNV_RD: ;
            S_CNV: begin
                cur_next = cur_sw;
                if (is_operand(cur_sw)) begin
                    emit_en  = 1'b1;
                    emit_val = cur_sw;
                    oc_next  = oc_reg + 1'b1;
                end else if (cur_sw == CH_LPAR) begin
                    push_en = 1'b1;
                    sp_next = sp_reg + 1'b1;
                end
                if ((is_operand(cur_sw) || cur_sw == CH_LPAR) && idx_reg != '0)
                    idx_next = idx_reg - 1'b1;
            end
            S_POP_RD: ;
            S_POP: begin
                if (cur_reg == CH_RPAR) begin
                    if (!stk_empty) sp_next = sp_reg - 1'b1;
                    if (!stk_empty && stk_rd != CH_LPAR) begin
                        emit_en = 1'b1;
                        oc_next = oc_reg + 1'b1;
                    end else if (idx_reg != '0) idx_next = idx_reg - 1'b1;
                end else begin
                    if (!stk_empty && prec_of(stk_rd) > prec_of(cur_reg)) begin
                        emit_en = 1'b1;
                        oc_next = oc_reg + 1'b1;
                        sp_next = sp_reg - 1'b1;
                    end else begin
                        push_en  = 1'b1;
                        push_val = cur_reg;
                        sp_next  = sp_reg + 1'b1;
                        if (idx_reg != '0) idx_next = idx_reg - 1'b1;
                    end
                end
            end
            S_FLUSH_RD: ;
            S_FLUSH: begin
                if (!stk_empty) begin
                    emit_en = 1'b1;
                    oc_next = oc_reg + 1'b1;
                    sp_next = sp_reg - 1'b1;
                end else if (oc_reg == '0) begin
                    res_next = '{8'd0, 1'b0, ST_OK, 1'b1};
                    mv_next  = 1'b1;
                end
            end
            S_EMIT_RD: ;
            S_EMIT: begin
                if (!mv_reg) begin
                    res_next = '{out_rd, 1'b1, ST_OK, (oc_reg == CW'(1))};
                    mv_next  = 1'b1;
                    oc_next  = oc_reg - 1'b1;
                end else if (m_ready) begin
                    mv_next = 1'b0;
                end
            end
            S_RESULT: begin
                if (m_ready && mv_reg) mv_next = 1'b0;
            end
            default: ;
        endcase
        // clear run state once the final beat leaves
        if (mv_reg && m_ready && res_reg.end_of_run) begin
            in_cnt_next = '0;
            tl_next     = 1'b0;
            sp_next     = '0;
            oc_next     = '0;
        end
    end

    assign m_valid = mv_reg;
    assign m_data  = res_reg;

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_LOAD;
            in_cnt_reg <= '0;
            idx_reg    <= '0;
            sp_reg     <= '0;
            oc_reg     <= '0;
            tl_reg     <= 1'b0;
            mv_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            in_cnt_reg <= in_cnt_next;
            idx_reg    <= idx_next;
            sp_reg     <= sp_next;
            oc_reg     <= oc_next;
            tl_reg     <= tl_next;
            mv_reg     <= mv_next;
        end
        cur_reg <= cur_next;
        res_reg <= res_next;
    end

`ifndef SYNTHESIS
    a_no_in_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken while result pending");
    a_sp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= MAXC) else $error("stack pointer out of range");
    a_err_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.char_valid) |-> m_data.end_of_run)
        else $error("error result not final");
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LOAD) |-> !m_valid) else $error("result during load");
`endif

endmodule
`default_nettype wire

[tb/tb_infix_to_prefix_converter_unit.sv]
// ----------------------------------------------------------------------------
// tb_infix_to_prefix_converter_unit
// Drives expressions beat by beat with random gaps and back-pressure, runs
// a software shunting-yard converter alongside, and checks every result
// beat field by field against the expected queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_infix_to_prefix_converter_unit;
    import itp_pkg::*;

    localparam int MAX_LEN = 64;
    localparam int WATCHDOG_LIMIT = 20000;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    itp_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    itp_out_t m_data;

    infix_to_prefix_converter_unit #(.MAX_LEN(MAX_LEN)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // predictor state
    logic [7:0] expr_buf[MAX_LEN];
    int         expr_len;
    logic       overflowed;
    itp_out_t   prefix_q[$];
    int         errors;
    int         idle_cycles;
    int         sent_count;
    bit         stim_done;

    function automatic bit is_alnum(logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic int rank(logic [7:0] c);
        if (c == CH_PLUS || c == CH_MINUS) return 1;
        if (c == CH_STAR || c == CH_SLASH) return 2;
        if (c == CH_CARET) return 3;
        return 0;
    endfunction

    function automatic bit nest_ok();
        logic [7:0] stk[$];
        logic [7:0] c;
        logic [7:0] want;
        for (int i = 0; i < expr_len; i++) begin
            c = expr_buf[i];
            if (c == CH_LPAR || c == CH_LBRC || c == CH_LBRK) begin
                stk.push_back(c);
            end else if (c == CH_RPAR || c == CH_RBRC || c == CH_RBRK) begin
                want = (c == CH_RPAR) ? CH_LPAR : (c == CH_RBRC) ? CH_LBRC : CH_LBRK;
                if (stk.size() == 0 || stk[$] != want) return 0;
                void'(stk.pop_back());
            end
        end
        return stk.size() == 0;
    endfunction

    // Work out the prefix beats of the held expression and queue them.
    task automatic predict_prefix();
        logic [7:0] stk[$];
        logic [7:0] built[$];
        logic [7:0] c;
        itp_out_t   r;
        if (overflowed) begin
            r = '{8'h00, 1'b0, ST_TOO_LONG, 1'b1};
            prefix_q.push_back(r);
        end else if (!nest_ok()) begin
            r = '{8'h00, 1'b0, ST_UNBALANCED, 1'b1};
            prefix_q.push_back(r);
        end else begin
            for (int i = expr_len - 1; i >= 0; i--) begin
                c = expr_buf[i];
                if (c == CH_LPAR) c = CH_RPAR;
                else if (c == CH_RPAR) c = CH_LPAR;
                if (is_alnum(c)) begin
                    built.push_back(c);
                end else if (c == CH_LPAR) begin
                    stk.push_back(c);
                end else if (c == CH_RPAR) begin
                    while (stk.size() > 0 && stk[$] != CH_LPAR) built.push_back(stk.pop_back());
                    if (stk.size() > 0) void'(stk.pop_back());
                end else begin
                    while (stk.size() > 0 && rank(stk[$]) > rank(c))
                        built.push_back(stk.pop_back());
                    stk.push_back(c);
                end
            end
            while (stk.size() > 0) built.push_back(stk.pop_back());
            if (built.size() == 0) begin
                r = '{8'h00, 1'b0, ST_OK, 1'b1};
                prefix_q.push_back(r);
            end else begin
                for (int j = built.size() - 1; j >= 0; j--) begin
                    r = '{built[j], 1'b1, ST_OK, (j == 0)};
                    prefix_q.push_back(r);
                end
            end
        end
        expr_len = 0;
        overflowed = 0;
    endtask

    task automatic take_char(itp_in_t beat);
        sent_count++;
        if (expr_len < MAX_LEN) begin
            expr_buf[expr_len] = beat.char_code;
            expr_len++;
        end else begin
            overflowed = 1;
        end
        if (beat.is_last) predict_prefix();
    endtask

    task automatic report_mismatch(string what, itp_out_t got, itp_out_t want);
        $display("mismatch %s: got %h/%b/%0d/%b want %h/%b/%0d/%b", what,
                 got.out_char, got.char_valid, got.status, got.end_of_run,
                 want.out_char, want.char_valid, want.status, want.end_of_run);
        errors++;
    endtask

    // Send one beat after a random gap; valid holds until accepted.
    task automatic send_beat(logic [7:0] c, logic last);
        itp_in_t beat;
        int gap;
        beat.char_code = c;
        beat.is_last = last;
        gap = $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0) gap = 0;
        // drop valid only across a real gap
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= beat;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        take_char(beat);
    endtask

    task automatic send_string(string s);
        for (int i = 0; i < s.len(); i++) send_beat(s[i], i == s.len() - 1);
    endtask

    function automatic logic [7:0] rand_operand();
        case ($urandom_range(0, 2))
            0: return 8'h30 + 8'($urandom_range(0, 9));
            1: return 8'h41 + 8'($urandom_range(0, 25));
            default: return 8'h61 + 8'($urandom_range(0, 25));
        endcase
    endfunction

    function automatic logic [7:0] rand_operator();
        case ($urandom_range(0, 5))
            0: return CH_PLUS;
            1: return CH_MINUS;
            2: return CH_STAR;
            3: return CH_SLASH;
            4: return CH_CARET;
            default: return 8'h20;
        endcase
    endfunction

    // Well-formed expression with random operands, operators and brackets.
    task automatic send_formed(int n_ops);
        logic [7:0] opens[$];
        logic [7:0] txt[$];
        logic [7:0] o;
        for (int k = 0; k <= n_ops; k++) begin
            if ($urandom_range(0, 3) == 0 && txt.size() < 40) begin
                o = ($urandom_range(0, 2) == 0) ? CH_LBRC :
                    ($urandom_range(0, 1) == 0) ? CH_LBRK : CH_LPAR;
                txt.push_back(o);
                opens.push_back(o);
            end
            txt.push_back(rand_operand());
            if (opens.size() > 0 && $urandom_range(0, 2) == 0) begin
                o = opens.pop_back();
                txt.push_back(o == CH_LPAR ? CH_RPAR : o == CH_LBRC ? CH_RBRC : CH_RBRK);
            end
            if (k < n_ops) txt.push_back(rand_operator());
        end
        while (opens.size() > 0) begin
            o = opens.pop_back();
            txt.push_back(o == CH_LPAR ? CH_RPAR : o == CH_LBRC ? CH_RBRC : CH_RBRK);
        end
        for (int i = 0; i < txt.size(); i++) send_beat(txt[i], i == txt.size() - 1);
    endtask

    // Directed table: rows of text; typed result only for error/empty rows.
    typedef struct {
        string    text;
        bit       typed;
        itp_out_t want;
    } dir_row_t;

    dir_row_t dir_rows[$];

    initial begin
        errors = 0;
        expr_len = 0;
        overflowed = 0;
        sent_count = 0;
        stim_done = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        dir_rows.push_back('{"a", 0, '0});
        dir_rows.push_back('{"a+b*c", 0, '0});
        dir_rows.push_back('{"(a-b)/c^d", 0, '0});
        dir_rows.push_back('{"a^b^c", 0, '0});
        dir_rows.push_back('{"{a+[b*c]}", 0, '0});
        dir_rows.push_back('{"(a+b", 1, '{8'h00, 1'b0, ST_UNBALANCED, 1'b1}});
        dir_rows.push_back('{"(a]", 1, '{8'h00, 1'b0, ST_UNBALANCED, 1'b1}});
        dir_rows.push_back('{"a)", 1, '{8'h00, 1'b0, ST_UNBALANCED, 1'b1}});
        dir_rows.push_back('{"()", 1, '{8'h00, 1'b0, ST_OK, 1'b1}});
        dir_rows.push_back('{"+", 0, '0});
        dir_rows.push_back('{"Z9 z0", 0, '0});
        foreach (dir_rows[i]) begin
            send_string(dir_rows[i].text);
            if (dir_rows[i].typed && prefix_q.size() > 0 && prefix_q[$] != dir_rows[i].want)
                report_mismatch("table", prefix_q[$], dir_rows[i].want);
        end
        // extreme bytes as operators, a single empty-ish byte
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat("x", 1'b1);
        send_beat(8'hFF, 1'b1);
        // exactly full buffer, then one beyond it
        for (int i = 0; i < MAX_LEN; i++) send_beat("q", i == MAX_LEN - 1);
        for (int i = 0; i <= MAX_LEN; i++) send_beat("r", i == MAX_LEN);

        // random part
        while (sent_count < 410) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    send_formed($urandom_range(0, 6));
                end
                6, 7: begin
                    int len;
                    len = $urandom_range(1, 8);
                    for (int i = 0; i < len; i++)
                        send_beat(8'($urandom_range(0, 255)), i == len - 1);
                end
                8: begin
                    send_formed($urandom_range(1, 4));
                    send_beat(CH_RPAR, 1'b1);
                end
                default: begin
                    int len;
                    len = $urandom_range(60, 70);
                    for (int i = 0; i < len; i++)
                        send_beat((i % 2) ? rand_operator() : rand_operand(), i == len - 1);
                end
            endcase
        end
        s_valid <= 1'b0;
        stim_done = 1;
    end

    // result side: random stall before each beat
    initial begin
        int stall;
        forever begin
            @(posedge aclk);
            if (m_ready && m_valid) begin
                m_ready <= 1'b0;
            end else if (!m_ready) begin
                stall = $urandom_range(0, 13);
                if ($urandom_range(0, 3) == 0) stall = 0;
                repeat (stall) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    // check accepted result beats
    always @(posedge aclk) begin
        itp_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (prefix_q.size() == 0) begin
                report_mismatch("unexpected beat", m_data, '0);
            end else begin
                want = prefix_q.pop_front();
                if (m_data !== want) report_mismatch("field", m_data, want);
            end
        end
    end

    // watchdog on cycles with no accepted beat
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        wait (stim_done);
        while (prefix_q.size() > 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (errors == 0 && prefix_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
